/* src/rdx_pkg.sv */
// Package for the integer to radix ASCII converter.
// Holds shared constants, the sequencer state type, the row control struct
// and the digit to character mapping. No dependencies.
package rdx_pkg;

	localparam int DEFAULT_MAX_DIGITS = 64;
	localparam int VALUE_W = 64;
	localparam int NARROW_W = 32;
	localparam int DIGIT_W = 6;
	localparam int RADIX_W = 8;
	localparam int CHAR_W = 8;
	localparam int STEP_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_RAW = 8'd0;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_CONV,
		ST_ALIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic shift;
	} row_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {2'b00, d};
		if (d < 6'd10) begin
			return dx + CHAR_ZERO;
		end else begin
			return dx + (CHAR_A - 8'd10);
		end
	endfunction

endpackage

/* src/rdx_cell.sv */
// One digit cell of the conversion row: doubles its digit and adds the carry
// from below, or takes its lower neighbor's digit when the row shifts.
// Depends on rdx_pkg.
module rdx_cell (
	input  logic                          clk,
	input  rdx_pkg::row_ctl_t             ctl,
	input  logic [rdx_pkg::DIGIT_W-1:0]   radix,
	input  logic                          carry_in,
	input  logic [rdx_pkg::DIGIT_W-1:0]   shift_in,
	output logic [rdx_pkg::DIGIT_W-1:0]   digit,
	output logic                          gen,
	output logic                          prop
);

	logic [rdx_pkg::DIGIT_W-1:0] digit_q;
	logic [rdx_pkg::DIGIT_W:0]   dbl;
	logic [rdx_pkg::DIGIT_W:0]   rad_x;
	logic [rdx_pkg::DIGIT_W:0]   diff;
	logic                        carry_out;

	assign rad_x = {1'b0, radix};
	assign dbl = {digit_q, carry_in};
	// 2d >= R always carries; 2d+1 == R carries only with a carry in
	assign gen = {digit_q, 1'b0} >= rad_x;
	assign prop = {digit_q, 1'b1} == rad_x;
	assign carry_out = gen | (prop & carry_in);
	assign diff = carry_out ? (dbl - rad_x) : dbl;
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.step) begin
			digit_q <= diff[rdx_pkg::DIGIT_W-1:0];
		end else if (ctl.shift) begin
			digit_q <= shift_in;
		end
	end

endmodule

/* src/rdx_row.sv */
// Row of digit cells holding the number in the chosen radix, least
// significant digit in cell 0, plus the carry network across the row.
// Depends on rdx_pkg and rdx_cell.
module rdx_row #(
	parameter int MAX_DIGITS = rdx_pkg::DEFAULT_MAX_DIGITS
) (
	input  logic                          clk,
	input  rdx_pkg::row_ctl_t             ctl,
	input  logic [rdx_pkg::DIGIT_W-1:0]   radix,
	input  logic                          bit_in,
	output logic [MAX_DIGITS:0]           carry,
	output logic [rdx_pkg::DIGIT_W-1:0]   top_digit
);

	logic [MAX_DIGITS-1:0]       gen;
	logic [MAX_DIGITS-1:0]       prop;
	logic [MAX_DIGITS-1:0]       gp;
	logic [MAX_DIGITS:0]         sum;
	logic [rdx_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];

	// carry into cell i is g | p & c, resolved with one adder
	assign gp = gen | prop;
	assign sum = {1'b0, gen} + {1'b0, gp} + {{MAX_DIGITS{1'b0}}, bit_in};
	assign carry[MAX_DIGITS-1:0] = sum[MAX_DIGITS-1:0] ^ gen ^ gp;
	assign carry[MAX_DIGITS] = sum[MAX_DIGITS];
	assign top_digit = digits[MAX_DIGITS-1];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		logic [rdx_pkg::DIGIT_W-1:0] below;
		if (i == 0) begin : g_bottom
			assign below = '0;
		end else begin : g_inner
			assign below = digits[i-1];
		end
		rdx_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.radix    (radix),
			.carry_in (carry[i]),
			.shift_in (below),
			.digit    (digits[i]),
			.gen      (gen[i]),
			.prop     (prop[i])
		);
	end

endmodule

/* src/integer_radix_to_ascii_top.sv */
// Top level of the integer to radix ASCII converter: request sequencer,
// output register and the digit cell row.
// Depends on rdx_pkg and rdx_row.
//
// Usage:
// A request (number, radix, is_signed, is_wide) is taken when req_valid is
// high and req_stall low. req_stall stays high while a request is being
// worked on. The answer is a stream of characters, most significant digit
// first, on character/last with rsp_valid/rsp_stall; last marks the final
// character. Radix 0 returns the low byte of number as one character.
// Operation: the row takes one input bit per cycle (32 bits narrow, 64
// wide), then shifts the top digit into place and sends one digit per
// cycle while the receiver does not stall.
// A leading minus sign, for signed radix 10 only, goes out ahead of the digits.
// When the receiver stalls, the held character stays and no new character
// is sent. The next request is taken once the last character sits in the
// output register. Reset empties the output register and returns to idle.
module integer_radix_to_ascii_top #(
	parameter int MAX_DIGITS = rdx_pkg::DEFAULT_MAX_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [rdx_pkg::VALUE_W-1:0]   number,
	input  logic [rdx_pkg::RADIX_W-1:0]   radix,
	input  logic                          is_signed,
	input  logic                          is_wide,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [rdx_pkg::CHAR_W-1:0]    character,
	output logic                          last
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	rdx_pkg::state_t st_q, st_d;
	logic [rdx_pkg::VALUE_W-1:0] val_q, val_d;
	logic [rdx_pkg::STEP_W-1:0]  stp_q, stp_d;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic [CNT_W-1:0]            lvl_q, lvl_d;
	logic [rdx_pkg::DIGIT_W-1:0] radix_q, radix_d;
	logic                        minus_q, minus_d;
	logic                        ovalid_q, ovalid_d;
	logic [rdx_pkg::CHAR_W-1:0]  ochar_q, ochar_d;
	logic                        olast_q, olast_d;

	rdx_pkg::row_ctl_t           ctl;
	logic [MAX_DIGITS:0]         carry;
	logic [rdx_pkg::DIGIT_W-1:0] top_digit;
	logic                        accept;
	logic                        out_free;
	logic                        neg;
	logic [rdx_pkg::VALUE_W-1:0] wide_mag;
	logic [rdx_pkg::NARROW_W-1:0] narrow_mag;

	assign req_stall = (st_q != rdx_pkg::ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign out_free = !ovalid_q || !rsp_stall;
	assign rsp_valid = ovalid_q;
	assign character = ochar_q;
	assign last = olast_q;

	assign neg = is_signed && (radix == rdx_pkg::RADIX_DEC) &&
		(is_wide ? number[rdx_pkg::VALUE_W-1] : number[rdx_pkg::NARROW_W-1]);
	assign wide_mag = neg ? (64'd0 - number) : number;
	assign narrow_mag = neg ? (32'd0 - number[rdx_pkg::NARROW_W-1:0]) :
		number[rdx_pkg::NARROW_W-1:0];

	rdx_row #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_row (
		.clk       (clk),
		.ctl       (ctl),
		.radix     (radix_q),
		.bit_in    (val_q[rdx_pkg::VALUE_W-1]),
		.carry     (carry),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rdx_pkg::ST_IDLE;
			minus_q <= 1'b0;
			ovalid_q <= 1'b0;
			cnt_q <= '0;
			lvl_q <= '0;
			stp_q <= '0;
		end else begin
			st_q <= st_d;
			minus_q <= minus_d;
			ovalid_q <= ovalid_d;
			cnt_q <= cnt_d;
			lvl_q <= lvl_d;
			stp_q <= stp_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		radix_q <= radix_d;
		ochar_q <= ochar_d;
		olast_q <= olast_d;
	end

	always_comb begin
		st_d = st_q;
		val_d = val_q;
		stp_d = stp_q;
		cnt_d = cnt_q;
		lvl_d = lvl_q;
		radix_d = radix_q;
		minus_d = minus_q;
		ovalid_d = ovalid_q && rsp_stall;
		ochar_d = ochar_q;
		olast_d = olast_q;
		ctl = '0;

		unique case (st_q)
			rdx_pkg::ST_IDLE: begin
				if (accept) begin
					val_d = number;
					minus_d = 1'b0;
					if (radix == rdx_pkg::RADIX_RAW) begin
						st_d = rdx_pkg::ST_RAW;
					end else begin
						st_d = rdx_pkg::ST_CONV;
						ctl.clear = 1'b1;
						minus_d = neg;
						cnt_d = CNT_ONE;
						if (is_wide) begin
							val_d = wide_mag;
							stp_d = rdx_pkg::STEP_W'(rdx_pkg::VALUE_W);
						end else begin
							val_d = {narrow_mag, {rdx_pkg::NARROW_W{1'b0}}};
							stp_d = rdx_pkg::STEP_W'(rdx_pkg::NARROW_W);
						end
						if (radix < rdx_pkg::RADIX_MIN || radix > rdx_pkg::RADIX_MAX) begin
							radix_d = rdx_pkg::RADIX_DEC[rdx_pkg::DIGIT_W-1:0];
						end else begin
							radix_d = radix[rdx_pkg::DIGIT_W-1:0];
						end
					end
				end
			end
			rdx_pkg::ST_RAW: begin
				if (out_free) begin
					ovalid_d = 1'b1;
					ochar_d = val_q[rdx_pkg::CHAR_W-1:0];
					olast_d = 1'b1;
					st_d = rdx_pkg::ST_IDLE;
				end
			end
			rdx_pkg::ST_CONV: begin
				ctl.step = 1'b1;
				val_d = {val_q[rdx_pkg::VALUE_W-2:0], 1'b0};
				stp_d = stp_q - 1'b1;
				if (cnt_q != CNT_MAX && carry[cnt_q]) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (stp_q == rdx_pkg::STEP_W'(1)) begin
					st_d = rdx_pkg::ST_ALIGN;
					lvl_d = cnt_d;
				end
			end
			rdx_pkg::ST_ALIGN: begin
				if (lvl_q == CNT_MAX) begin
					st_d = rdx_pkg::ST_EMIT;
				end else begin
					ctl.shift = 1'b1;
					lvl_d = lvl_q + 1'b1;
				end
			end
			rdx_pkg::ST_EMIT: begin
				if (out_free && !minus_q) begin
					ovalid_d = 1'b1;
					ochar_d = rdx_pkg::digit_char(top_digit);
					olast_d = (cnt_q == CNT_ONE);
					ctl.shift = 1'b1;
					cnt_d = cnt_q - 1'b1;
					if (cnt_q == CNT_ONE) begin
						st_d = rdx_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				st_d = rdx_pkg::ST_IDLE;
			end
		endcase

		// sign goes out ahead of any digit
		if (minus_q && out_free && (st_q == rdx_pkg::ST_CONV ||
				st_q == rdx_pkg::ST_ALIGN || st_q == rdx_pkg::ST_EMIT)) begin
			ovalid_d = 1'b1;
			ochar_d = rdx_pkg::CHAR_MINUS;
			olast_d = 1'b0;
			minus_d = 1'b0;
		end
	end

	a_idle_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rdx_pkg::ST_IDLE) |-> !minus_q)
		else $error("sign still pending in idle");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rdx_pkg::ST_EMIT) |-> (cnt_q != '0 && cnt_q <= CNT_MAX))
		else $error("digit count out of range while sending");

	a_align_level: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == rdx_pkg::ST_ALIGN) |-> (lvl_q >= cnt_q && lvl_q <= CNT_MAX))
		else $error("row alignment past top");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted without going busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != rdx_pkg::ST_IDLE && st_d == rdx_pkg::ST_IDLE) |=> (ovalid_q && olast_q))
		else $error("request finished without a last character");

endmodule
